FILE: hw/rtl/assert_macros.svh
// Shared assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another condition in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/mcps_pkg.sv
`default_nettype none

package mcps_pkg;

    // Input word modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_SCAN  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // MIPS primary opcodes that build constants
    localparam logic [5:0] OP_LUI   = 6'b001111;
    localparam logic [5:0] OP_ADDI  = 6'b001000;
    localparam logic [5:0] OP_ADDIU = 6'b001001;
    localparam logic [5:0] OP_ORI   = 6'b001101;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_REG  = 1'b1;

    localparam int NUM_REGS        = 32;
    localparam int REG_IDX_W       = 5;
    localparam int SLOT_W          = 3;
    localparam int POS_W           = 30;
    localparam int NUM_TARGETS_DEF = 8;
    localparam int OUT_DEPTH       = 8;

    typedef struct packed {
        logic [1:0]        mode;
        logic [31:0]       word;
        logic [SLOT_W-1:0] slot;
    } mcps_in_t;

    typedef struct packed {
        logic              kind;
        logic [31:0]       first_address;
        logic [31:0]       second_address;
        logic [SLOT_W-1:0] target_index;
        logic              first_hit;
        logic              last;
    } mcps_out_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic upd;
    } mcps_tgt_ctl_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] index;
        logic              first;
    } mcps_match_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mcps_ram.sv
`default_nettype none

module mcps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mcps_targets.sv
`default_nettype none

module mcps_targets
    import mcps_pkg::*;
#(
    parameter int NUM_TARGETS = NUM_TARGETS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mcps_tgt_ctl_t     ctl,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [31:0]       load_value,
    input  wire logic [31:0]       raw_value,
    input  wire logic [31:0]       reg_value,
    output mcps_match_t            raw_match,
    output mcps_match_t            reg_match
);

    localparam int TIDX_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

    logic [31:0]            value_reg [NUM_TARGETS];
    logic [NUM_TARGETS-1:0] valid_reg;
    logic [NUM_TARGETS-1:0] seen_reg;

    logic              raw_found;
    logic              reg_found;
    logic [TIDX_W-1:0] raw_idx;
    logic [TIDX_W-1:0] reg_idx;

    // Lowest valid slot wins: walk from the top down.
    always_comb
    begin
        raw_found = 1'b0;
        reg_found = 1'b0;
        raw_idx   = '0;
        reg_idx   = '0;
        for (int i = NUM_TARGETS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (value_reg[i] == raw_value))
            begin
                raw_found = 1'b1;
                raw_idx   = TIDX_W'(i);
            end
            if (valid_reg[i] && (value_reg[i] == reg_value))
            begin
                reg_found = 1'b1;
                reg_idx   = TIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        raw_match.hit   = ctl.scan && raw_found;
        raw_match.index = SLOT_W'(32'(raw_idx));
        raw_match.first = !seen_reg[raw_idx];
        reg_match.hit   = ctl.upd && reg_found;
        reg_match.index = SLOT_W'(32'(reg_idx));
        // A raw hit on the same slot in this word has already marked it.
        reg_match.first = !seen_reg[reg_idx] && !(raw_match.hit && (raw_idx == reg_idx));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_TARGETS; i++)
        begin
            if (ctl.load && (32'(slot) == 32'(i)))
            begin
                value_reg[i] <= load_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            seen_reg  <= '0;
        end
        else if (ctl.clear)
        begin
            seen_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_TARGETS; i++)
            begin
                if (ctl.load && (32'(slot) == 32'(i)))
                begin
                    valid_reg[i] <= 1'b1;
                    seen_reg[i]  <= 1'b0;
                end
            end
            if (raw_match.hit)
            begin
                seen_reg[raw_idx] <= 1'b1;
            end
            if (reg_match.hit)
            begin
                seen_reg[reg_idx] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mcps_out_fifo.sv
`default_nettype none

module mcps_out_fifo
    import mcps_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push_a,
    input  wire mcps_out_t              data_a,
    input  wire logic                   push_b,
    input  wire mcps_out_t              data_b,
    output logic                        valid,
    input  wire logic                   stall,
    output mcps_out_t                   data,
    output logic [$clog2(DEPTH):0]      level
);

    // DEPTH is a power of two; pointers wrap naturally.
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    mcps_out_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   wr_ptr_b;
    logic               pop;
    logic [CNT_W-1:0]   count_next;
    logic [PTR_W-1:0]   wr_ptr_next;

    assign valid    = (count_reg != '0);
    assign data     = mem_reg[rd_ptr_reg];
    assign level    = count_reg;
    assign pop      = valid && !stall;
    assign wr_ptr_b = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        count_next  = count_reg + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_a) + PTR_W'(push_b);
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            mem_reg[wr_ptr_reg] <= data_a;
        end
        if (push_b)
        begin
            mem_reg[wr_ptr_b] <= data_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mips_constant_pointer_scanner.sv
// MIPS constant pointer scanner.
// Scan channel (scan_valid / scan_stall / scan_data) takes one word per cycle
// while scan_stall is low: mode load writes a target value into a slot, mode
// start begins a new image and mode scan reads one instruction or data word.
// Hit channel (hit_valid / hit_stall / hit_data) returns up to two results per
// scanned word, the raw data pointer first; last marks the final one.
// An accepted word is registered into stage 1, which writes its results into
// the output queue; the two results of a word enter the queue together and
// leave it in turn. The register file and the LUI address table sit in
// single-port-read RAMs read in the accept cycle and written in the cycle
// after, with a one-deep forwarding path for back-to-back accesses to the
// same register.
// Results go into an eight-word output queue; scan_stall rises when the queue
// could not take the results of one more word, so a receiver stall fills the
// queue first and then holds the scan side. Nothing is ever dropped.
// Reset: registers, LUI addresses, position and hit marks read as zero at once
// through per-entry valid bits (no clearing pass); all targets are invalid
// and base_address is zero, which the user writes through the APB port at
// byte address 0 only while the block is idle; the block does not enforce it.
`default_nettype none

module mips_constant_pointer_scanner
    import mcps_pkg::*;
#(
    parameter int NUM_TARGETS = NUM_TARGETS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        scan_valid,
    output logic             scan_stall,
    input  wire mcps_in_t    scan_data,
    output logic             hit_valid,
    input  wire logic        hit_stall,
    output mcps_out_t        hit_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LVL_W = $clog2(OUT_DEPTH) + 1;
    localparam int SUM_W = LVL_W + 1;

    // Configuration
    logic [31:0] base_reg;

    // Stage 1: the word accepted in the previous cycle
    logic         s1_valid_reg;
    mcps_in_t     s1_data_reg;

    // Image state
    logic [POS_W-1:0]    pos_reg;
    logic [NUM_REGS-1:0] reg_vld_reg;
    logic [NUM_REGS-1:0] lui_vld_reg;

    // Forwarding of the last write to each RAM
    logic                 fwd_reg_valid_reg;
    logic [REG_IDX_W-1:0] fwd_reg_addr_reg;
    logic [31:0]          fwd_reg_data_reg;
    logic                 fwd_lui_valid_reg;
    logic [REG_IDX_W-1:0] fwd_lui_addr_reg;
    logic [31:0]          fwd_lui_data_reg;

    logic                 accept;
    logic [31:0]          reg_rdata;
    logic [31:0]          lui_rdata;
    logic [5:0]           op;
    logic [REG_IDX_W-1:0] rs;
    logic [REG_IDX_W-1:0] rt;
    logic [15:0]          imm;
    logic                 is_scan;
    logic                 is_start;
    logic                 is_load;
    logic [31:0]          addr;
    logic [31:0]          rs_val;
    logic [31:0]          lui_val;
    logic [31:0]          calc_val;
    logic [31:0]          new_val;
    logic                 upd;
    logic                 reg_we;
    logic                 lui_we;
    logic [31:0]          lui_result;

    mcps_tgt_ctl_t tgt_ctl;
    mcps_match_t   raw_match;
    mcps_match_t   reg_match;
    mcps_out_t     res_raw;
    mcps_out_t     res_reg;
    mcps_out_t     push_a_data;
    logic          push_a;
    logic          push_b;
    logic [LVL_W-1:0] level;
    logic [SUM_W-1:0] need;

    // APB: register 0 at byte addresses 0 to 3, addresses 4 to 7 read zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? base_reg : 32'd0;

    // Hold the scan side when the queue might not take one more word's results.
    assign need = SUM_W'(level) + (s1_valid_reg ? SUM_W'(2) : SUM_W'(0)) + SUM_W'(2);
    assign scan_stall = (need > SUM_W'(OUT_DEPTH));
    assign accept     = scan_valid && !scan_stall;

    // Read both RAMs straight from the incoming word.
    mcps_ram #(
        .WIDTH(32),
        .DEPTH(NUM_REGS)
    ) u_reg_ram (
        .clk   (clk),
        .we    (reg_we),
        .waddr (rt),
        .wdata (new_val),
        .raddr (scan_data.word[25:21]),
        .rdata (reg_rdata)
    );

    mcps_ram #(
        .WIDTH(32),
        .DEPTH(NUM_REGS)
    ) u_lui_ram (
        .clk   (clk),
        .we    (lui_we),
        .waddr (rt),
        .wdata (addr),
        .raddr (scan_data.word[20:16]),
        .rdata (lui_rdata)
    );

    // Decode the word in stage 1.
    assign op       = s1_data_reg.word[31:26];
    assign rs       = s1_data_reg.word[25:21];
    assign rt       = s1_data_reg.word[20:16];
    assign imm      = s1_data_reg.word[15:0];
    assign is_scan  = s1_valid_reg && (s1_data_reg.mode == MODE_SCAN);
    assign is_start = s1_valid_reg && (s1_data_reg.mode == MODE_START);
    assign is_load  = s1_valid_reg && (s1_data_reg.mode == MODE_LOAD);
    assign addr     = base_reg + {pos_reg, 2'b00};

    // Take the last write if it hit the same register; an entry never
    // written since the image start reads zero.
    always_comb
    begin
        if (fwd_reg_valid_reg && (fwd_reg_addr_reg == rs))
        begin
            rs_val = fwd_reg_data_reg;
        end
        else
        begin
            rs_val = reg_vld_reg[rs] ? reg_rdata : 32'd0;
        end
        if (fwd_lui_valid_reg && (fwd_lui_addr_reg == rt))
        begin
            lui_val = fwd_lui_data_reg;
        end
        else
        begin
            lui_val = lui_vld_reg[rt] ? lui_rdata : 32'd0;
        end
    end

    always_comb
    begin
        upd      = 1'b0;
        calc_val = 32'd0;
        case (op)
            OP_LUI:
            begin
                upd      = 1'b1;
                calc_val = {imm, 16'h0000};
            end
            OP_ADDI, OP_ADDIU:
            begin
                upd      = 1'b1;
                calc_val = rs_val + {{16{imm[15]}}, imm};
            end
            OP_ORI:
            begin
                upd      = 1'b1;
                calc_val = rs_val | {16'h0000, imm};
            end
            default:
            begin
                upd      = 1'b0;
                calc_val = 32'd0;
            end
        endcase
    end

    // Register 0 stays zero; its LUI address is still kept.
    assign new_val    = (rt == '0) ? 32'd0 : calc_val;
    assign reg_we     = is_scan && upd;
    assign lui_we     = is_scan && (op == OP_LUI);
    assign lui_result = (op == OP_LUI) ? addr : lui_val;

    always_comb
    begin
        tgt_ctl.load  = is_load;
        tgt_ctl.clear = is_start;
        tgt_ctl.scan  = is_scan;
        tgt_ctl.upd   = reg_we;
    end

    mcps_targets #(
        .NUM_TARGETS(NUM_TARGETS)
    ) u_targets (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tgt_ctl),
        .slot       (s1_data_reg.slot),
        .load_value (s1_data_reg.word),
        .raw_value  (s1_data_reg.word),
        .reg_value  (new_val),
        .raw_match  (raw_match),
        .reg_match  (reg_match)
    );

    // Build results; the raw pointer goes first when both are found.
    always_comb
    begin
        res_raw.kind           = KIND_DATA;
        res_raw.first_address  = addr;
        res_raw.second_address = 32'd0;
        res_raw.target_index   = raw_match.index;
        res_raw.first_hit      = raw_match.first;
        res_raw.last           = !reg_match.hit;

        res_reg.kind           = KIND_REG;
        res_reg.first_address  = lui_result;
        res_reg.second_address = addr;
        res_reg.target_index   = reg_match.index;
        res_reg.first_hit      = reg_match.first;
        res_reg.last           = 1'b1;

        push_a      = raw_match.hit || reg_match.hit;
        push_b      = raw_match.hit && reg_match.hit;
        push_a_data = raw_match.hit ? res_raw : res_reg;
    end

    mcps_out_fifo #(
        .DEPTH(OUT_DEPTH)
    ) u_out_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_a (push_a),
        .data_a (push_a_data),
        .push_b (push_b),
        .data_b (res_reg),
        .valid  (hit_valid),
        .stall  (hit_stall),
        .data   (hit_data),
        .level  (level)
    );

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= scan_data;
        end
        fwd_reg_addr_reg <= rt;
        fwd_reg_data_reg <= new_val;
        fwd_lui_addr_reg <= rt;
        fwd_lui_data_reg <= addr;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg          <= 32'd0;
            s1_valid_reg      <= 1'b0;
            pos_reg           <= '0;
            reg_vld_reg       <= '0;
            lui_vld_reg       <= '0;
            fwd_reg_valid_reg <= 1'b0;
            fwd_lui_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && (paddr[2] == 1'b0))
            begin
                base_reg <= pwdata;
            end
            s1_valid_reg      <= accept;
            fwd_reg_valid_reg <= reg_we;
            fwd_lui_valid_reg <= lui_we;
            if (is_start)
            begin
                pos_reg     <= '0;
                reg_vld_reg <= '0;
                lui_vld_reg <= '0;
            end
            else if (is_scan)
            begin
                pos_reg <= pos_reg + POS_W'(1);
                if (reg_we)
                begin
                    reg_vld_reg[rt] <= 1'b1;
                end
                if (lui_we)
                begin
                    lui_vld_reg[rt] <= 1'b1;
                end
            end
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_enters_s1, accept, s1_valid_reg, "accepted word missing in stage 1")
    `ASSERT_NEXT(a_fwd_follows_write, reg_we, fwd_reg_valid_reg && (fwd_reg_data_reg == $past(new_val)), "register write not forwarded")
    `ASSERT_NEXT(a_start_clears_pos, is_start, (pos_reg == '0) && (reg_vld_reg == '0), "image start left state")
    `ASSERT_CLK(a_queue_bound, SUM_W'(level) <= SUM_W'(OUT_DEPTH), "output queue overflow")

endmodule

`default_nettype wire

FILE: tb/mips_constant_pointer_scanner_tb.sv
`timescale 1ns / 1ps

module mips_constant_pointer_scanner_tb;
    import mcps_pkg::*;

    // Table size of the instance below (default parameter)
    localparam int NUM_TARGETS = NUM_TARGETS_DEF;

    // Mode code the block must ignore; the package has no name for it
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    // Byte address of base_address on the APB port
    localparam logic [2:0] ADDR_BASE = 3'd0;

    // Length of the long receiver hold-off that backs up the whole block
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        scan_valid = 1'b0;
    logic        scan_stall;
    mcps_in_t    scan_data = '0;
    logic        hit_valid;
    logic        hit_stall = 1'b0;
    mcps_out_t   hit_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mips_constant_pointer_scanner dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan_data  (scan_data),
        .hit_valid  (hit_valid),
        .hit_stall  (hit_stall),
        .hit_data   (hit_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scanner model: register file, LUI address table, target table,
    // hit marks and word position, plus the base address last written.
    // ------------------------------------------------------------------
    logic [31:0] base_addr = '0;
    logic [31:0] reg_file    [NUM_REGS];
    logic [31:0] lui_addr_of [NUM_REGS];
    logic [31:0] tgt_val     [NUM_TARGETS];
    logic        tgt_ok      [NUM_TARGETS];
    logic        hit_mark    [NUM_TARGETS];
    logic [POS_W-1:0] word_pos;

    // Results predicted for accepted words, oldest first
    mcps_out_t pending_hits [$];

    // Input words waiting for the driver
    mcps_in_t word_queue [$];

    // Driver bookkeeping: a word is in flight while offered != taken
    int offered = 0;
    int taken = 0;

    // Idle percentages of each side, changed per phase
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Long hold-off requests, served by the receiver process
    int hold_orders = 0;
    int hold_served = 0;
    int hold_left = 0;

    int errors = 0;
    int config_errors = 0;

    // Lowest valid slot that holds the value, or -1
    function automatic int lowest_match(input logic [31:0] v);
        for (int i = 0; i < NUM_TARGETS; i++)
        begin
            if (tgt_ok[i] && tgt_val[i] == v)
                return i;
        end
        return -1;
    endfunction

    function automatic mcps_out_t make_hit(input logic kind, input logic [31:0] a1,
                                           input logic [31:0] a2, input int slot);
        mcps_out_t h;
        h.kind           = kind;
        h.first_address  = a1;
        h.second_address = a2;
        h.target_index   = slot[SLOT_W-1:0];
        h.first_hit      = !hit_mark[slot];
        h.last           = 1'b0;
        return h;
    endfunction

    // Advance the model by one accepted word and queue the results it causes
    task automatic predict_word(input mcps_in_t w);
        logic [31:0] addr;
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic        upd;
        int          slot;
        int          n;
        mcps_out_t   found [2];
        n = 0;
        upd = 1'b0;
        case (w.mode)
            MODE_LOAD:
            begin
                if (int'(w.slot) < NUM_TARGETS)
                begin
                    tgt_val[w.slot]  = w.word;
                    tgt_ok[w.slot]   = 1'b1;
                    hit_mark[w.slot] = 1'b0;
                end
            end
            MODE_START:
            begin
                // Targets survive an image start; everything else drops
                for (int i = 0; i < NUM_REGS; i++)
                begin
                    reg_file[i]    = '0;
                    lui_addr_of[i] = '0;
                end
                for (int i = 0; i < NUM_TARGETS; i++)
                    hit_mark[i] = 1'b0;
                word_pos = '0;
            end
            MODE_SCAN:
            begin
                addr = base_addr + {word_pos, 2'b00};
                // Raw data pointer comes first
                slot = lowest_match(w.word);
                if (slot >= 0)
                begin
                    found[n] = make_hit(KIND_DATA, addr, 32'h0, slot);
                    hit_mark[slot] = 1'b1;
                    n++;
                end
                op  = w.word[31:26];
                rs  = w.word[25:21];
                rt  = w.word[20:16];
                imm = w.word[15:0];
                if (op == OP_LUI)
                begin
                    reg_file[rt]    = {imm, 16'h0};
                    lui_addr_of[rt] = addr;
                    upd = 1'b1;
                end
                else if (op == OP_ADDI || op == OP_ADDIU)
                begin
                    // Sign-extended immediate, wraps with no trap
                    reg_file[rt] = reg_file[rs] + {{16{imm[15]}}, imm};
                    upd = 1'b1;
                end
                else if (op == OP_ORI)
                begin
                    reg_file[rt] = reg_file[rs] | {16'h0, imm};
                    upd = 1'b1;
                end
                if (upd)
                begin
                    // Register 0 reads zero even right after a write to it
                    reg_file[0] = '0;
                    slot = lowest_match(reg_file[rt]);
                    if (slot >= 0)
                    begin
                        found[n] = make_hit(KIND_REG, lui_addr_of[rt], addr, slot);
                        hit_mark[slot] = 1'b1;
                        n++;
                    end
                end
                if (n > 0)
                    found[n-1].last = 1'b1;
                for (int i = 0; i < n; i++)
                    pending_hits.push_back(found[i]);
                word_pos = word_pos + 1'b1;
            end
            default:
            begin
                // Ignored mode: no results, no state change
            end
        endcase
    endtask

    task automatic flag_error(input string msg);
        if (errors < 10)
            $display("%0s", msg);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Accept and check at the rising edge: predict each accepted word,
    // compare each accepted result with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        mcps_out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                reg_file[i]    = '0;
                lui_addr_of[i] = '0;
            end
            for (int i = 0; i < NUM_TARGETS; i++)
            begin
                tgt_val[i]  = '0;
                tgt_ok[i]   = 1'b0;
                hit_mark[i] = 1'b0;
            end
            word_pos = '0;
        end
        else
        begin
            if (scan_valid && !scan_stall)
            begin
                predict_word(scan_data);
                taken++;
            end
            if (hit_valid && !hit_stall)
            begin
                if (pending_hits.size() == 0)
                begin
                    flag_error($sformatf(
                        "unexpected result: kind %0d first %h second %h idx %0d fh %0d last %0d",
                        hit_data.kind, hit_data.first_address, hit_data.second_address,
                        hit_data.target_index, hit_data.first_hit, hit_data.last));
                end
                else
                begin
                    want = pending_hits.pop_front();
                    if (hit_data.kind !== want.kind
                        || hit_data.first_address !== want.first_address
                        || hit_data.second_address !== want.second_address
                        || hit_data.target_index !== want.target_index
                        || hit_data.first_hit !== want.first_hit
                        || hit_data.last !== want.last)
                    begin
                        flag_error($sformatf(
                            "mismatch: expected kind %0d first %h second %h idx %0d fh %0d last %0d, got kind %0d first %h second %h idx %0d fh %0d last %0d",
                            want.kind, want.first_address, want.second_address,
                            want.target_index, want.first_hit, want.last,
                            hit_data.kind, hit_data.first_address, hit_data.second_address,
                            hit_data.target_index, hit_data.first_hit, hit_data.last));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: at the falling edge, hold a word that is still waiting,
    // otherwise offer the next one or idle at random.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            scan_valid <= 1'b0;
        else if (offered == taken)
        begin
            if (word_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                scan_data  <= word_queue.pop_front();
                scan_valid <= 1'b1;
                offered++;
            end
            else
                scan_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here on request
    always @(negedge clk)
    begin
        if (hold_served != hold_orders)
        begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_orders;
        end
        if (hold_left != 0)
        begin
            hit_stall <= 1'b1;
            hold_left--;
        end
        else
            hit_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [31:0] plant_value [NUM_TARGETS];

    function automatic mcps_in_t make_word(input logic [1:0] mode, input logic [31:0] w,
                                           input logic [2:0] slot);
        mcps_in_t it;
        it.mode = mode;
        it.word = w;
        it.slot = slot;
        return it;
    endfunction

    function automatic logic [31:0] i_type(input logic [5:0] op, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    task automatic push_scan(input logic [31:0] w);
        word_queue.push_back(make_word(MODE_SCAN, w, 3'($urandom)));
    endtask

    task automatic plant(input int slot, input logic [31:0] v);
        word_queue.push_back(make_word(MODE_LOAD, v, slot[2:0]));
        plant_value[slot] = v;
    endtask

    task automatic push_start();
        word_queue.push_back(make_word(MODE_START, $urandom, 3'($urandom)));
    endtask

    // Target values with structure that constant building can reach
    function automatic logic [31:0] random_target();
        logic [15:0] half;
        logic [31:0] v;
        half = 16'($urandom);
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = {16'h0, half};
            2: v = {half, 16'h0};
            3: v = {half, half | 16'h8000};
            default: v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        endcase
        return v;
    endfunction

    // One APB transfer on base_address: setup cycle, then access until pready
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_BASE;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (wr)
            base_addr = wdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_base(input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, value, rd);
        apb_access(1'b0, 32'h0, rd);
        if (rd !== value)
        begin
            $display("base_address readback: expected %h, got %h", value, rd);
            config_errors++;
        end
    endtask

    // Let the sender run dry, then wait out every result and the pipeline
    task automatic drain();
        while (word_queue.size() != 0 || offered != taken)
            @(posedge clk);
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Mostly LUI + completing instruction pairs aimed at planted targets,
    // with raw target words, reloads, image starts and noise mixed in
    task automatic queue_random_run(input int count);
        int          n;
        int          choice;
        int          t;
        logic [31:0] v;
        logic [15:0] hi;
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        for (int i = 0; i < NUM_TARGETS; i++)
            plant(i, random_target());
        push_start();
        n = 0;
        while (n < count)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 40)
            begin
                t  = $urandom_range(0, NUM_TARGETS - 1);
                v  = plant_value[t];
                rt = 5'($urandom_range(0, 31));
                case ($urandom_range(0, 2))
                    0: op = OP_ORI;
                    1: op = OP_ADDI;
                    default: op = OP_ADDIU;
                endcase
                // ADDI/ADDIU sign-extend the low half, so carry into the LUI half
                hi = (op == OP_ORI) ? v[31:16] : v[31:16] + {15'h0, v[15]};
                push_scan(i_type(OP_LUI, 5'($urandom), rt, hi));
                n++;
                if ($urandom_range(0, 3) == 0)
                begin
                    push_scan($urandom);
                    n++;
                end
                // Mostly complete from the same register; sometimes break the chain
                rs = ($urandom_range(0, 5) == 0) ? 5'($urandom) : rt;
                push_scan(i_type(op, rs, rt, v[15:0]));
                n++;
            end
            else if (choice < 50)
            begin
                push_scan(plant_value[$urandom_range(0, NUM_TARGETS - 1)]);
                n++;
            end
            else if (choice < 54)
            begin
                plant($urandom_range(0, NUM_TARGETS - 1), random_target());
                n++;
            end
            else if (choice < 57)
            begin
                push_start();
                n++;
            end
            else if (choice < 59)
                word_queue.push_back(make_word(MODE_IGNORED, $urandom, 3'($urandom)));
            else if (choice < 80)
            begin
                case ($urandom_range(0, 3))
                    0: op = OP_LUI;
                    1: op = OP_ADDI;
                    2: op = OP_ADDIU;
                    default: op = OP_ORI;
                endcase
                push_scan(i_type(op, 5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)),
                                 16'($urandom)));
                n++;
            end
            else
            begin
                push_scan($urandom);
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part; base just below the top so addresses wrap early
        tx_idle_pct = 34;
        rx_idle_pct = 59;
        set_base(32'hFFFF_FFF8);
        push_scan(i_type(OP_LUI, 5'd0, 5'd8, 16'h1234));     // no targets valid yet
        word_queue.push_back(make_word(MODE_IGNORED, 32'hFFFF_FFFF, 3'd7));
        plant(0, 32'h1234_5678);
        plant(2, 32'h3C09_ABCD);                             // the LUI r9 word itself
        plant(3, 32'h0000_0000);
        plant(4, 32'h3508_5678);                             // ORI r8 word = its result
        plant(5, 32'hABCD_0000);
        plant(7, 32'hFFFF_FFFF);
        push_start();
        push_scan(32'h1234_5678);                            // raw pointer only
        push_scan(i_type(OP_LUI, 5'd0, 5'd8, 16'h1234));
        push_scan(i_type(OP_ORI, 5'd8, 5'd8, 16'h5678));     // raw pointer on slot 4, register pointer on slot 0
        push_scan(i_type(OP_LUI, 5'd0, 5'd9, 16'hABCD));     // raw and register, two slots
        push_scan(i_type(OP_LUI, 5'd0, 5'd8, 16'h3508));
        push_scan(i_type(OP_ORI, 5'd8, 5'd8, 16'h5678));     // both results on one slot
        push_scan(i_type(OP_LUI, 5'd0, 5'd10, 16'hFFFF));
        push_scan(i_type(OP_ORI, 5'd10, 5'd10, 16'hFFFF));   // all ones
        push_scan(i_type(OP_ADDI, 5'd10, 5'd10, 16'h0001));  // wraps to zero
        push_scan(i_type(OP_ADDIU, 5'd0, 5'd11, 16'h8000));  // sign-extended immediate
        push_scan(i_type(OP_ADDI, 5'd11, 5'd11, 16'h8000));
        push_scan(i_type(OP_LUI, 5'd0, 5'd0, 16'h1234));     // write to register 0
        push_scan(32'h0000_0000);
        push_scan(32'hFFFF_FFFF);
        plant(0, 32'h1234_5678);                             // reload clears the hit mark
        push_scan(32'h1234_5678);
        push_start();
        push_scan(32'h1234_5678);
        drain();

        // Random part, sender lightly idle and receiver heavily
        set_base(32'h0000_0000);
        queue_random_run(270);
        drain();

        // Swap the idle rates
        tx_idle_pct = 59;
        rx_idle_pct = 34;
        set_base(32'hFFFF_FFFF);
        queue_random_run(270);
        drain();

        // No idling; hold the receiver off long enough to back up the scan side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_base($urandom);
        queue_random_run(130);
        hold_orders++;
        drain();

        set_base($urandom);
        queue_random_run(130);
        drain();

        if (errors == 0 && config_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
